[rtl/sat_pkg.sv]
package sat_pkg;

  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_DROP   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_SHORT = 2'd2,
    STATUS_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [7:0]  sector;
    logic [15:0] head;
    logic [63:0] tail;
    logic [31:0] total;
  } entry_t;

  typedef struct packed {
    logic   commit;
    op_t    op;
    logic   sik;
    logic   full;
    logic   nonempty;
    entry_t key;
  } cmd_t;

  // zero every byte after the first nul of the ten byte code
  function automatic logic [79:0] clean_code(input logic [79:0] code);
    logic [79:0] res;
    logic        seen;
    res  = code;
    seen = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (seen) begin
        res[i*8 +: 8] = 8'd0;
      end else if (code[i*8 +: 8] == 8'd0) begin
        seen = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

[rtl/sat_cell.sv]
module sat_cell (
  input  logic             clk,
  input  sat_pkg::cmd_t    cmd,
  input  logic             live,
  input  logic             at_fill,
  input  logic             found_in,
  input  logic             hit_in,
  input  sat_pkg::entry_t  left,
  input  sat_pkg::entry_t  right,
  output logic             found_out,
  output logic             hit_out,
  output sat_pkg::entry_t  q
);
  import sat_pkg::*;

  logic        sec_lt;
  logic        sec_eq;
  logic        code_lt;
  logic        code_eq;
  logic        lt;
  logic        eq;
  logic        ge;
  logic        first;
  logic        my_hit;
  logic [32:0] sum;

  always_comb begin
    sec_lt  = q.sector < cmd.key.sector;
    sec_eq  = q.sector == cmd.key.sector;
    code_lt = {q.head, q.tail} < {cmd.key.head, cmd.key.tail};
    code_eq = {q.head, q.tail} == {cmd.key.head, cmd.key.tail};
    if (cmd.sik) begin
      lt = sec_lt || (sec_eq && code_lt);
      eq = sec_eq && code_eq;
    end else begin
      lt = code_lt;
      eq = code_eq;
    end
    ge        = (live && !lt) || at_fill;
    first     = ge && !found_in;
    my_hit    = first && live && eq;
    found_out = found_in || ge;
    hit_out   = hit_in || my_hit;
    sum       = {1'b0, q.total} + {1'b0, cmd.key.total};
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (cmd.op)
        OP_INSERT: begin
          if (my_hit) begin
            q.total <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          end else if (first && !hit_in && !cmd.full) begin
            q <= cmd.key;
          end else if (found_in && !hit_in && !cmd.full) begin
            q <= left;
          end
        end
        OP_POP: begin
          if (cmd.nonempty) begin
            q <= right;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/sorted_aggregation_table.sv]
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    opcode sector_code code_head code_tail
//                                            quantity drop_count rank
// out      output     out_valid / out_stall  status out_sector out_code_head
//                                            out_code_tail out_total entries_held
// cfg      input      cfg_write              cfg_data (sector_in_key)
//
// an item is taken in idle; in exec the row of cells compares and shifts, with in_stall high
// the result register lets the next item in while a result waits on out_stall
// a finished item waits in the exec state until the result register is free
// rst clears the fill count, the key mode and the valid flag; slot contents stay as they are
module sorted_aggregation_table #(
  parameter int DEPTH = sat_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  sector_code,
  input  logic [15:0] code_head,
  input  logic [63:0] code_tail,
  input  logic [15:0] quantity,
  input  logic [4:0]  drop_count,
  input  logic [3:0]  rank,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  out_sector,
  output logic [15:0] out_code_head,
  output logic [63:0] out_code_tail,
  output logic [31:0] out_total,
  output logic [4:0]  entries_held
);
  import sat_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int CMPW = (CW > 5) ? CW : 5;

  state_t       state;
  state_t       state_next;
  logic         sector_in_key;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;

  op_t          item_op;
  entry_t       item_key;
  logic [4:0]   item_drop;
  logic [3:0]   item_rank;
  logic [79:0]  clean;

  logic         commit;
  logic         out_free;
  cmd_t         cmd;
  entry_t       cell_q [DEPTH];
  logic         found [DEPTH+1];
  logic         hit [DEPTH+1];

  status_t      res_status;
  entry_t       res_entry;
  status_t      status_q;
  logic [IW-1:0] rank_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_in_key <= 1'b0;
    end else if (cfg_write) begin
      sector_in_key <= cfg_data;
    end
  end

  assign clean = clean_code({code_head, code_tail});

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_op        <= op_t'(opcode);
      item_key.sector <= sector_code;
      item_key.head  <= clean[79:64];
      item_key.tail  <= clean[63:0];
      item_key.total <= {16'd0, quantity};
      item_drop      <= drop_count;
      item_rank      <= rank;
    end
  end

  // state machine
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b0;
    commit   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_EXEC: begin
        in_stall = 1'b1;
        commit   = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // row of cells
  always_comb begin
    cmd.commit   = commit;
    cmd.op       = item_op;
    cmd.sik      = sector_in_key;
    cmd.full     = fill == CW'(DEPTH);
    cmd.nonempty = fill != '0;
    cmd.key      = item_key;
  end

  assign found[0] = 1'b0;
  assign hit[0]   = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sat_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .live      (fill > CW'(i)),
      .at_fill   (fill == CW'(i)),
      .found_in  (found[i]),
      .hit_in    (hit[i]),
      .left      ((i == 0) ? item_key : cell_q[(i == 0) ? 0 : i - 1]),
      .right     (cell_q[(i == DEPTH - 1) ? i : i + 1]),
      .found_out (found[i+1]),
      .hit_out   (hit[i+1]),
      .q         (cell_q[i])
    );
  end

  // result and fill update
  assign rank_idx = IW'(item_rank);

  always_comb begin
    res_status = STATUS_OK;
    res_entry  = '0;
    fill_next  = fill;
    case (item_op)
      OP_INSERT: begin
        if (!hit[DEPTH]) begin
          if (cmd.full) begin
            res_status = STATUS_FULL;
          end else begin
            fill_next = fill + CW'(1);
          end
        end
      end
      OP_POP: begin
        if (!cmd.nonempty) begin
          res_status = STATUS_SHORT;
        end else begin
          res_entry = cell_q[0];
          fill_next = fill - CW'(1);
        end
      end
      OP_DROP: begin
        if (CMPW'(item_drop) > CMPW'(fill)) begin
          res_status = STATUS_SHORT;
        end else begin
          fill_next = CW'(CMPW'(fill) - CMPW'(item_drop));
        end
      end
      OP_READ: begin
        if (CMPW'(item_rank) >= CMPW'(fill)) begin
          res_status = STATUS_RANGE;
        end else begin
          res_entry = cell_q[rank_idx];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit) begin
        fill <= fill_next;
      end
      out_valid <= commit || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status_q      <= res_status;
      out_sector    <= res_entry.sector;
      out_code_head <= res_entry.head;
      out_code_tail <= res_entry.tail;
      out_total     <= res_entry.total;
      entries_held  <= 5'(fill_next);
    end
  end

  assign status = status_q;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(fill))
    else $error("fill count moved without a commit");

  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("commit without a result");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_q == STATUS_FULL) |-> fill == CW'(DEPTH))
    else $error("full reported below depth");

endmodule
